// File: rtl/bin_sort_engine_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the bin sort checker
// ---------------------------------------------------------------------------
`ifndef BIN_SORT_ENGINE_MACROS_SVH
`define BIN_SORT_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define BSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bin sort engine check failed");

// Next-cycle implication, sampled on the rising clock edge
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bin sort engine check failed");

`endif

// File: rtl/bse_pkg.sv
// ---------------------------------------------------------------------------
// bse_pkg: shared widths of the bin sort engine
// Field widths of the value channel and of the per-bin counters.
// ---------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

    // Width of the value fields on both channels
    localparam int VAL_W = 8;

    // Width of bin counts and item counters (holds counts up to 127)
    localparam int CNT_W = 7;

endpackage

`default_nettype wire

// File: rtl/bin_sort_engine.sv
// ---------------------------------------------------------------------------
// bin_sort_engine: counting bin sort over a stream of unsigned values
// Bin counts live in one synchronous RAM, updated by read-modify-write.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one value per beat; i_last
//   marks the final beat of a set. A set loads at one beat per cycle. A beat
//   that arrives with MAX_ITEMS items already held is not counted and flags
//   the set as dropped. After the marked beat the input stalls while the
//   bins are drained: each bin from 0 to the largest value seen passes
//   through a RAM read (S_RD) and a count check (S_CNT), and each held item
//   is emitted as one beat (S_EMIT). When bin 0 is occupied, the first
//   result follows the marked beat through S_RD, S_CNT, S_EMIT and the
//   output register.
//   Output channel (o_out_valid / i_out_stall) delivers the values in
//   ascending order through an output register; o_last_of_run marks the final
//   beat. When the receiver stalls, emission holds and the beat stays put.
//   Drained bins are written back to zero on the way.
//   After reset a clearing pass writes all 2^min(VALUE_BITS,8) bins to zero,
//   one bin per cycle, with the input stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module bin_sort_engine
    import bse_pkg::*;
#(
    parameter int VALUE_BITS = 8,
    parameter int MAX_ITEMS  = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [VAL_W-1:0] i_value,
    input  wire logic             i_last,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [VAL_W-1:0]      o_sorted_value,
    output logic                  o_last_of_run,
    output logic                  o_dropped
);

    // Only the value port's bits can reach the bins
    localparam int IDX_BITS = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int NUM_BINS = 1 << IDX_BITS;
    localparam logic [IDX_BITS-1:0] BIN_LAST = '1;
    localparam logic [CNT_W-1:0]    ITEM_CAP = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0]    CNT_ONE  = CNT_W'(1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CNT  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]          r_state;
    logic [IDX_BITS-1:0] r_bin;
    logic [IDX_BITS-1:0] r_largest;
    logic [CNT_W-1:0]    r_items;
    logic [CNT_W-1:0]    r_emitted;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_ovf;
    logic                r_s1_valid;

    logic [CNT_W-1:0]    r_mem [NUM_BINS];
    logic [CNT_W-1:0]    r_mem_q;
    logic [IDX_BITS-1:0] r_rd_addr;
    logic                r_wr_valid;
    logic [IDX_BITS-1:0] r_wr_addr;
    logic [CNT_W-1:0]    r_wr_data;

    logic                r_out_valid;
    logic [IDX_BITS-1:0] r_out_value;
    logic                r_out_last;
    logic                r_out_drop;

    logic [IDX_BITS-1:0] in_idx;
    logic                in_acc;
    logic                counted;
    logic                out_free;
    logic                out_load;
    logic [CNT_W-1:0]    fwd_cnt;
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    logic [CNT_W-1:0]    wr_data;
    logic [IDX_BITS-1:0] rd_addr;

    // Handshake decode
    assign in_idx   = i_value[IDX_BITS-1:0];
    assign in_acc   = i_in_valid && (r_state == S_LOAD);
    assign counted  = in_acc && (r_items < ITEM_CAP);
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_EMIT) && out_free;

    // Forward the write that landed on the same edge as the read
    assign fwd_cnt = (r_wr_valid && (r_wr_addr == r_rd_addr)) ? r_wr_data : r_mem_q;

    // Select the RAM write: clear pass, count update, or zero after a drain read
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_bin;
        wr_data = '0;
        if (r_state == S_CLR) begin
            wr_en = 1'b1;
        end else if (r_s1_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_rd_addr;
            wr_data = CNT_W'(fwd_cnt + CNT_ONE);
        end else if (r_state == S_CNT) begin
            wr_en = 1'b1;
        end
    end

    assign rd_addr = (r_state == S_LOAD) ? in_idx : r_bin;

    // Bin count RAM, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_mem_q   <= r_mem[rd_addr];
        r_rd_addr <= rd_addr;
        r_wr_addr <= wr_addr;
        r_wr_data <= wr_data;
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= r_bin;
            r_out_last  <= (CNT_W'(r_emitted + CNT_ONE) == r_items);
            r_out_drop  <= r_ovf;
        end
    end

    // Sequencer: clear, load, then walk bins and emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_bin       <= '0;
            r_largest   <= '0;
            r_items     <= '0;
            r_emitted   <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= counted;
            r_wr_valid <= wr_en;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_bin <= IDX_BITS'(r_bin + 1'b1);
                    if (r_bin == BIN_LAST) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (counted) begin
                        r_items <= CNT_W'(r_items + CNT_ONE);
                        if (in_idx > r_largest) begin
                            r_largest <= in_idx;
                        end
                    end else if (in_acc) begin
                        r_ovf <= 1'b1;
                    end
                    if (in_acc && i_last) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    r_cnt <= fwd_cnt;
                    if (fwd_cnt != '0) begin
                        r_state <= S_EMIT;
                    end else if (r_bin == r_largest) begin
                        // Empty top bin: close the set
                        r_state   <= S_LOAD;
                        r_bin     <= '0;
                        r_largest <= '0;
                        r_items   <= '0;
                        r_emitted <= '0;
                        r_ovf     <= 1'b0;
                    end else begin
                        r_bin   <= IDX_BITS'(r_bin + 1'b1);
                        r_state <= S_RD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_cnt     <= CNT_W'(r_cnt - CNT_ONE);
                        r_emitted <= CNT_W'(r_emitted + CNT_ONE);
                        if (r_cnt == CNT_ONE) begin
                            if (r_bin == r_largest) begin
                                // Drain done: reset set state
                                r_state   <= S_LOAD;
                                r_bin     <= '0;
                                r_largest <= '0;
                                r_items   <= '0;
                                r_emitted <= '0;
                                r_ovf     <= 1'b0;
                            end else begin
                                r_bin   <= IDX_BITS'(r_bin + 1'b1);
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_CLR;
                    r_bin   <= '0;
                end
            endcase
        end
    end

    // Drive ports
    assign o_in_stall     = (r_state != S_LOAD);
    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = VAL_W'(r_out_value);
    assign o_last_of_run  = r_out_last;
    assign o_dropped      = r_out_drop;

endmodule

`default_nettype wire

// File: rtl/bse_checker.sv
// ---------------------------------------------------------------------------
// bse_checker: port-level checks for the bin sort engine
// Watches both channels of the top level and flags sequencing slips.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bin_sort_engine_macros.svh"

module bse_checker
    import bse_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire logic             i_last,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire logic [VAL_W-1:0] o_sorted_value,
    input wire logic             o_last_of_run,
    input wire logic             o_dropped
);

    // Gather the output beat and the handshake terms the checks need
    logic             out_held;
    logic             last_taken;
    logic [VAL_W+1:0] out_beat;

    assign out_held   = o_out_valid && i_out_stall;
    assign last_taken = i_in_valid && !o_in_stall && i_last;
    assign out_beat   = {o_sorted_value, o_last_of_run, o_dropped};

    // Hold a stalled output beat
    `BSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_beat))

    // Stall the input once the marked beat of a set is taken
    `BSE_ASSERT_NEXT(a_stall_after_last, i_clk, i_rst_n, last_taken, o_in_stall)

    // Launch a new output beat only while the input is held off
    `BSE_ASSERT_IMPL(a_emit_in_drain, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind bin_sort_engine bse_checker u_bse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_last         (i_last),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_sorted_value (o_sorted_value),
    .o_last_of_run  (o_last_of_run),
    .o_dropped      (o_dropped)
);

`default_nettype wire

// File: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for bin_sort_engine
// Sends sets of values with the final beat marked and predicts the ascending
// sorted stream of each set, including the capacity limit and dropped flag.
// Compares every output beat field by field against the oldest prediction.
// ---------------------------------------------------------------------------

module testbench
    import bse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_BITS   = 8;
    localparam int MAX_ITEMS    = 64;
    localparam int NUM_BINS     = 1 << VALUE_BITS;
    localparam int TARGET_ITEMS = 330;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 600;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             dropped;
    } t_sorted_beat;

    typedef enum int {
        STALL_NONE,
        STALL_SCATTER,
        STALL_RUNS
    } t_stall_style;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_LOW
    } t_spread;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [VAL_W-1:0] i_value;
    logic             i_last;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [VAL_W-1:0] o_sorted_value;
    logic             o_last_of_run;
    logic             o_dropped;

    bin_sort_engine #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_ITEMS  (MAX_ITEMS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_of_run  (o_last_of_run),
        .o_dropped      (o_dropped)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted sorter state and the sorted beats still owed by the block
    logic [CNT_W-1:0] sort_bins [NUM_BINS];
    int unsigned      held_count;
    int unsigned      peak_value;
    logic             set_dropped;
    t_sorted_beat     sorted_queue [$];

    int unsigned error_count;
    int unsigned items_sent;
    int unsigned burst_left;

    // Tally one accepted value; on the marked beat emit the sorted set and clear
    task automatic tally_value(input logic [VAL_W-1:0] value, input logic last);
        int unsigned  bin;
        int unsigned  left;
        int unsigned  emitted;
        int unsigned  idx;
        t_sorted_beat beat;
        idx = int'(value) & (NUM_BINS - 1);
        if (held_count < MAX_ITEMS) begin
            sort_bins[idx] = sort_bins[idx] + 1'b1;
            if (idx > peak_value) peak_value = idx;
            held_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!last) return;
        emitted = 0;
        for (bin = 0; bin <= peak_value && bin < NUM_BINS; bin++) begin
            left = sort_bins[bin];
            while (left > 0 && emitted < MAX_ITEMS) begin
                beat.value   = VAL_W'(bin);
                beat.last    = (emitted + 1 == held_count);
                beat.dropped = set_dropped;
                sorted_queue.push_back(beat);
                emitted++;
                left--;
            end
        end
        for (bin = 0; bin < NUM_BINS; bin++) sort_bins[bin] = '0;
        held_count  = 0;
        peak_value  = 0;
        set_dropped = 1'b0;
    endtask

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int expected, input int got);
        $display("%0t ns: mismatch on %s: expected %0d, got %0d", $realtime, what,
                 expected, got);
        error_count++;
    endtask

    // Send one beat; the sender runs in bursts with random gaps between them
    task automatic send_value(input logic [VAL_W-1:0] value, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        i_in_valid = 1'b1;
        i_value    = value;
        i_last     = last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tally_value(value, last);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Hold the sender until every predicted beat has come out
    task automatic wait_for_sorted();
        while (sorted_queue.size() != 0) @(negedge i_clk);
    endtask

    // Pick a random value with one of several spreads
    function automatic logic [VAL_W-1:0] pick_value(input t_spread spread,
                                                    input int unsigned base);
        case (spread)
            SPREAD_NARROW: pick_value = VAL_W'(base + $urandom_range(0, 3));
            SPREAD_LOW:    pick_value = VAL_W'($urandom_range(0, 7));
            default:       pick_value = VAL_W'($urandom_range(0, NUM_BINS - 1));
        endcase
    endfunction

    // Send a set of random values of the given length, marked on its final beat
    task automatic send_random_set(input int unsigned length);
        t_spread     spread;
        int unsigned base;
        int unsigned n;
        spread = t_spread'($urandom_range(0, 2));
        base   = $urandom_range(0, NUM_BINS - 4);
        for (n = 0; n < length; n++) send_value(pick_value(spread, base), n == length - 1);
    endtask

    // Single-value sets and sets spanning the whole value range
    task automatic test_extreme_values();
        send_value(8'd0, 1'b1);
        send_value(8'd255, 1'b1);
        send_value(8'd255, 1'b0);
        send_value(8'd0, 1'b1);
        send_value(8'd170, 1'b0);
        send_value(8'd85, 1'b0);
        send_value(8'd1, 1'b0);
        send_value(8'd128, 1'b0);
        send_value(8'd254, 1'b1);
    endtask

    // Duplicate values must come out once per occurrence
    task automatic test_repeated_values();
        repeat (4) send_value(8'd5, 1'b0);
        send_value(8'd5, 1'b1);
        send_value(8'd255, 1'b0);
        send_value(8'd7, 1'b0);
        send_value(8'd255, 1'b0);
        send_value(8'd7, 1'b0);
        send_value(8'd0, 1'b0);
        send_value(8'd255, 1'b1);
    endtask

    // Exactly full set, one beat over with the marked beat dropped, several over
    task automatic test_capacity_edges();
        send_random_set(MAX_ITEMS);
        send_random_set(MAX_ITEMS + 1);
        send_random_set(MAX_ITEMS + $urandom_range(2, 6));
    endtask

    // Random sets, mostly short, now and then at or beyond capacity
    task automatic test_random_sets();
        int unsigned length;
        bit          paused;
        paused = 1'b0;
        while (items_sent < TARGET_ITEMS) begin
            case ($urandom_range(0, 15))
                0:       length = MAX_ITEMS;
                1:       length = MAX_ITEMS + $urandom_range(1, 4);
                default: length = $urandom_range(1, 12);
            endcase
            send_random_set(length);
            if (!paused && items_sent > TARGET_ITEMS / 2) begin
                wait_for_sorted();
                paused = 1'b1;
            end
        end
    endtask

    // Receiver stall pattern: quiet stretches, scattered stalls, long stall runs
    t_stall_style stall_style;
    int unsigned  style_left = 0;
    int unsigned  run_left   = 0;
    logic         run_stall  = 1'b0;

    always @(negedge i_clk) begin
        if (style_left == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 2));
            style_left  = $urandom_range(50, 300);
        end
        style_left--;
        case (stall_style)
            STALL_SCATTER: begin
                i_out_stall <= ($urandom_range(0, 9) < 3);
            end
            STALL_RUNS: begin
                if (run_left == 0) begin
                    run_stall = !run_stall;
                    run_left  = $urandom_range(1, 15);
                end
                run_left--;
                i_out_stall <= run_stall;
            end
            default: begin
                i_out_stall <= 1'b0;
            end
        endcase
    end

    // Check each output beat against the oldest prediction
    always @(posedge i_clk) begin
        t_sorted_beat beat;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sorted_queue.size() == 0) begin
                $display("%0t ns: unexpected output beat, value %0d", $realtime,
                         o_sorted_value);
                error_count++;
            end else begin
                beat = sorted_queue.pop_front();
                if (o_sorted_value !== beat.value)
                    report_mismatch("sorted_value", beat.value, o_sorted_value);
                if (o_last_of_run !== beat.last)
                    report_mismatch("last_of_run", beat.last, o_last_of_run);
                if (o_dropped !== beat.dropped)
                    report_mismatch("dropped", beat.dropped, o_dropped);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_value     = '0;
        i_last      = 1'b0;
        error_count = 0;
        items_sent  = 0;
        burst_left  = 0;
        held_count  = 0;
        peak_value  = 0;
        set_dropped = 1'b0;
        for (int b = 0; b < NUM_BINS; b++) sort_bins[b] = '0;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extreme_values();
        test_repeated_values();
        test_capacity_edges();
        test_random_sets();

        // Drain whatever is still owed, then let the block settle
        wait_for_sorted();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/bse_pkg.sv
rtl/bin_sort_engine.sv
rtl/bse_checker.sv
tb/sv/testbench.sv
